### design/lpc_synthesis_filter_macros.svh
// Assertion macros included by the synthesis filter module.
`ifndef LPC_SYNTHESIS_FILTER_MACROS_SVH
`define LPC_SYNTHESIS_FILTER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lsf_pkg.sv
// Constants, register indexes and the coefficient lookup of the synthesis filter.
package lsf_pkg;

  localparam int FILTER_ORDER = 10;
  localparam int REG_TAPS = 10;
  localparam int SAMPLE_W = 16;
  localparam int ACC_W = 42;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_COEF_0_3 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_4_7 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_8_9 = 2'd2;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32'h0000_8000);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(33'sh0_8000_0000));

  function automatic logic signed [SAMPLE_W-1:0] lag_coef(
    input logic [63:0] coef_lo,
    input logic [63:0] coef_mid,
    input logic [31:0] coef_hi,
    input int          k
  );
    logic signed [SAMPLE_W-1:0] c;
    c = '0;
    if (k < 4) begin
      c = coef_lo[16*k +: 16];
    end else if (k < 8) begin
      c = coef_mid[16*(k-4) +: 16];
    end else if (k < REG_TAPS) begin
      c = coef_hi[16*(k-8) +: 16];
    end
    return c;
  endfunction

endpackage

### design/lsf_in_if.sv
// Excitation sample channel with valid/ready handshake.
interface lsf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lsf_pkg::SAMPLE_W-1:0]  excitation_sample;
  logic                                 last_in;

  modport source (output valid, output excitation_sample, output last_in, input ready);
  modport sink (input valid, input excitation_sample, input last_in, output ready);
endinterface

### design/lsf_out_if.sv
// Synthesized sample channel with valid/ready handshake.
interface lsf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lsf_pkg::SAMPLE_W-1:0]  synth_sample;
  logic                                 last_out;

  modport source (output valid, output synth_sample, output last_out, input ready);
  modport sink (input valid, input synth_sample, input last_out, output ready);
endinterface

### design/lsf_cfg_if.sv
// Coefficient register write channel with valid/ready handshake.
interface lsf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lsf_pkg::CFG_INDEX_W-1:0]    index;
  logic [lsf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/lpc_synthesis_filter.sv
// Order-ten all-pole LPC synthesis filter with coefficient registers.
//
// The block takes signed 16-bit excitation samples on the samples channel and
// returns one synthesized sample per input beat on the synth channel, with the
// subframe marker carried alongside. Coefficients are written on the cfg
// channel, which is always ready; index 0 holds lags 1 to 4, index 1 lags 5 to
// 8 and index 2 lags 9 and 10, and other indexes are ignored.
// An accepted beat lands in the input register and moves on to the output
// register once that is empty or being read, and its result is presented
// from the output register until the receiver takes it.
// Without a stall, one beat per cycle is sustained: the ten products and their
// sum form a single combinational pass from the input register and the output
// history to the output register, and the history is updated in that same edge.
// When the receiver stalls, the result holds in the output register and one
// more beat can wait in the input register before samples.ready drops.
// Synchronous reset empties both registers and clears the output history and
// all coefficients to zero.
module lpc_synthesis_filter (
  input  logic          clk,
  input  logic          rst,
  lsf_in_if.sink        samples,
  lsf_out_if.source     synth,
  lsf_cfg_if.sink       cfg
);

  `include "lpc_synthesis_filter_macros.svh"

  logic [63:0] coef_lo;
  logic [63:0] coef_mid;
  logic [31:0] coef_hi;

  logic                                 s_valid;
  logic signed [lsf_pkg::SAMPLE_W-1:0]  s_sample;
  logic                                 s_last;

  logic                                 o_valid;
  logic signed [lsf_pkg::SAMPLE_W-1:0]  o_sample;
  logic                                 o_last;

  logic signed [lsf_pkg::SAMPLE_W-1:0]  history [lsf_pkg::FILTER_ORDER];

  logic                                 advance;
  logic                                 in_take;
  logic signed [lsf_pkg::ACC_W-1:0]     acc;
  logic signed [lsf_pkg::ACC_W-1:0]     scaled;
  logic signed [lsf_pkg::SAMPLE_W-1:0]  y_next;

  assign advance = s_valid && (!o_valid || synth.ready);
  assign samples.ready = !s_valid || advance;
  assign in_take = samples.valid && samples.ready;
  assign cfg.ready = 1'b1;

  assign synth.valid = o_valid;
  assign synth.synth_sample = o_sample;
  assign synth.last_out = o_last;

  always_comb begin
    logic signed [31:0] prod;
    acc = lsf_pkg::ACC_W'(s_sample) <<< 14;
    for (int k = 0; k < lsf_pkg::FILTER_ORDER; k++) begin
      prod = lsf_pkg::lag_coef(coef_lo, coef_mid, coef_hi, k) * history[k];
      acc = acc + (lsf_pkg::ACC_W'(prod) <<< 1);
    end
    scaled = (acc <<< 2) + lsf_pkg::ROUND_BIAS;
    if (scaled > lsf_pkg::SAT_MAX) begin
      y_next = 16'sh7FFF;
    end else if (scaled < lsf_pkg::SAT_MIN) begin
      y_next = -16'sh8000;
    end else begin
      y_next = scaled[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_lo <= '0;
      coef_mid <= '0;
      coef_hi <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        lsf_pkg::REG_COEF_0_3: coef_lo <= cfg.data;
        lsf_pkg::REG_COEF_4_7: coef_mid <= cfg.data;
        lsf_pkg::REG_COEF_8_9: coef_hi <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samples.ready) begin
      s_valid <= samples.valid;
    end
    if (in_take) begin
      s_sample <= samples.excitation_sample;
      s_last <= samples.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (synth.ready) begin
      o_valid <= 1'b0;
    end
    if (advance) begin
      o_sample <= y_next;
      o_last <= s_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < lsf_pkg::FILTER_ORDER; k++) begin
        history[k] <= '0;
      end
    end else if (advance) begin
      for (int k = lsf_pkg::FILTER_ORDER - 1; k > 0; k--) begin
        history[k] <= history[k-1];
      end
      history[0] <= y_next;
    end
  end

  `LSF_ASSERT_NEXT(a_in_lands, clk, rst, in_take, s_valid, "Accepted beat missing from input register.")
  `LSF_ASSERT_NEXT(a_wait_holds, clk, rst, s_valid && !advance, s_valid, "Waiting beat was dropped.")
  `LSF_ASSERT_NEXT(a_result_loaded, clk, rst, advance, o_valid && (history[0] == o_sample), "Result and history disagree.")
  `LSF_ASSERT_SAME(a_no_overwrite, clk, rst, o_valid && !synth.ready, !advance, "Stalled result overwritten.")

endmodule
